// File: rtl/ffe_pkg.sv
// Shared types and constants for the frame fill engine.
// No dependencies; every other file of the block but ffe_ram imports this package.
`default_nettype none

package ffe_pkg;

    // Default geometry of the panel and of the frame store.
    localparam int PANEL_WIDTH_DEF  = 128;
    localparam int PANEL_HEIGHT_DEF = 128;
    localparam int STORE_WIDTH_DEF  = 128;
    localparam int STORE_PIXELS_DEF = 16384;

    localparam int PIXEL_W = 16;
    localparam int COORD_W = 16;
    // Width of the signed clipping sums: a 16-bit start plus a 16-bit length.
    localparam int SUM_W   = 18;

    // Rotation mode that swaps the clip width and height.
    localparam logic [1:0] ROT_LANDSCAPE = 2'd1;

    // Configuration register indexes.
    localparam logic REG_ROTATION = 1'b0;

    typedef enum logic [2:0] {
        REQ_PIXEL = 3'd0,
        REQ_HRUN  = 3'd1,
        REQ_VRUN  = 3'd2,
        REQ_RECT  = 3'd3,
        REQ_FILL  = 3'd4,
        REQ_READ  = 3'd5
    } req_type_t;

    // What the checked request turns into.
    typedef enum logic [2:0] {
        ACT_REJECT,
        ACT_EMPTY,
        ACT_DRAW,
        ACT_FILL,
        ACT_READ
    } act_t;

    typedef struct packed {
        logic load;        // capture the incoming request word
        logic check;       // register clip results and start address
        logic step;        // write one pixel of a run or rectangle
        logic sweep_start; // point the address at entry zero
        logic sweep_clear; // the sweep writes zero instead of the color
        logic sweep_step;  // write one entry of a linear sweep
        logic read;        // read the store at the current address
        logic post;        // load the result register
    } ffe_cmd_t;

    typedef struct packed {
        act_t act;
        logic last_pixel;
        logic sweep_last;
        logic out_free;
    } ffe_status_t;

endpackage

`default_nettype wire

// File: rtl/ffe_req_if.sv
// Request channel: valid/ready handshake with the drawing request payload.
// Depends on ffe_pkg for field widths.
`default_nettype none

interface ffe_req_if;
    import ffe_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [2:0]                req_type;
    logic signed [COORD_W-1:0] x_pos;
    logic signed [COORD_W-1:0] y_pos;
    logic signed [COORD_W-1:0] run_width;
    logic signed [COORD_W-1:0] run_height;
    logic [PIXEL_W-1:0]        pixel_color;

    modport source (
        output valid, req_type, x_pos, y_pos, run_width, run_height, pixel_color,
        input  ready
    );

    modport sink (
        input  valid, req_type, x_pos, y_pos, run_width, run_height, pixel_color,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/ffe_rsp_if.sv
// Result channel: valid/ready handshake with the read value and accept flag.
// Depends on ffe_pkg for field widths.
`default_nettype none

interface ffe_rsp_if;
    import ffe_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] read_value;
    logic               was_accepted;

    modport source (
        output valid, read_value, was_accepted,
        input  ready
    );

    modport sink (
        input  valid, read_value, was_accepted,
        output ready
    );

endinterface

`default_nettype wire

// File: rtl/ffe_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ffe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ffe_ctrl.sv
// Sequencer of the frame fill engine: clear pass, request check, draw,
// fill, read and result hand-off. Depends on ffe_pkg.
`default_nettype none

module ffe_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ffe_pkg::ffe_status_t status,
    output ffe_pkg::ffe_cmd_t        cmd
);
    import ffe_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_DRAW,
        ST_FILL,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_start = 1'b1;
                cmd.sweep_clear = 1'b1;
                state_next      = ST_CLEAR;
            end
            ST_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                unique case (status.act)
                    ACT_FILL:
                    begin
                        cmd.sweep_start = 1'b1;
                        state_next      = ST_FILL;
                    end
                    ACT_DRAW:   state_next = ST_DRAW;
                    ACT_READ:   state_next = ST_READ;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_DRAW:
            begin
                cmd.step = 1'b1;
                if (status.last_pixel)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.post   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/ffe_datapath.sv
// Datapath of the frame fill engine: request registers, clipping, address
// walker, frame store and result register. Depends on ffe_pkg and ffe_ram.
`default_nettype none

module ffe_datapath #(
    parameter int PANEL_WIDTH  = ffe_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = ffe_pkg::PANEL_HEIGHT_DEF,
    parameter int STORE_WIDTH  = ffe_pkg::STORE_WIDTH_DEF,
    parameter int STORE_PIXELS = ffe_pkg::STORE_PIXELS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire ffe_pkg::ffe_cmd_t                    cmd,
    output ffe_pkg::ffe_status_t                      status,
    input  wire logic [1:0]                           rotation,
    input  wire logic [2:0]                           req_type,
    input  wire logic signed [ffe_pkg::COORD_W-1:0]   x_pos,
    input  wire logic signed [ffe_pkg::COORD_W-1:0]   y_pos,
    input  wire logic signed [ffe_pkg::COORD_W-1:0]   run_width,
    input  wire logic signed [ffe_pkg::COORD_W-1:0]   run_height,
    input  wire logic [ffe_pkg::PIXEL_W-1:0]          pixel_color,
    input  wire logic                                 rsp_ready,
    output logic                                      rsp_valid,
    output logic [ffe_pkg::PIXEL_W-1:0]               read_value,
    output logic                                      was_accepted
);
    import ffe_pkg::*;

    localparam int PANEL_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CNT_W     = $clog2(PANEL_MAX + 1);
    localparam int SPAN      = PANEL_MAX * STORE_WIDTH + PANEL_MAX;
    localparam int ADDR_TOP  = (SPAN > STORE_PIXELS) ? SPAN : STORE_PIXELS;
    localparam int ADDR_W    = $clog2(ADDR_TOP + 1);
    localparam int IDX_W     = $clog2(STORE_PIXELS);

    // Request word.
    logic [2:0]                req_reg;
    logic signed [COORD_W-1:0] x_reg;
    logic signed [COORD_W-1:0] y_reg;
    logic signed [COORD_W-1:0] w_reg;
    logic signed [COORD_W-1:0] h_reg;
    logic [PIXEL_W-1:0]        color_reg;

    // Walker state.
    logic [ADDR_W-1:0] addr_reg,  addr_next;
    logic [ADDR_W-1:0] base_reg,  base_next;
    logic [CNT_W-1:0]  col_reg,   col_next;
    logic [CNT_W-1:0]  row_reg,   row_next;
    logic [CNT_W-1:0]  wlen_reg;
    logic              zero_reg;
    logic              acc_reg;
    logic              hit_reg;

    // Result register.
    logic               out_valid_reg;
    logic [PIXEL_W-1:0] out_value_reg;
    logic               out_acc_reg;

    // Clipping.
    logic [CNT_W-1:0]        clip_w;
    logic [CNT_W-1:0]        clip_h;
    logic signed [SUM_W-1:0] clip_w_s;
    logic signed [SUM_W-1:0] clip_h_s;
    logic signed [SUM_W-1:0] x_s;
    logic signed [SUM_W-1:0] y_s;
    logic signed [SUM_W-1:0] end_x;
    logic signed [SUM_W-1:0] end_y;
    logic signed [SUM_W-1:0] len_w;
    logic signed [SUM_W-1:0] len_h;
    logic                    in_clip;
    logic                    w_pos;
    logic                    h_pos;
    logic [CNT_W-1:0]        eff_w;
    logic [CNT_W-1:0]        eff_h;
    logic [ADDR_W-1:0]       start_addr;
    logic                    start_in_store;
    act_t                    act;

    logic               ram_we;
    logic [PIXEL_W-1:0] ram_wdata;
    logic [PIXEL_W-1:0] ram_rdata;
    logic               addr_in_store;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req_type;
            x_reg     <= x_pos;
            y_reg     <= y_pos;
            w_reg     <= run_width;
            h_reg     <= run_height;
            color_reg <= pixel_color;
        end
    end

    always_comb
    begin
        clip_w = (rotation == ROT_LANDSCAPE) ? CNT_W'(PANEL_HEIGHT) : CNT_W'(PANEL_WIDTH);
        clip_h = (rotation == ROT_LANDSCAPE) ? CNT_W'(PANEL_WIDTH)  : CNT_W'(PANEL_HEIGHT);
        clip_w_s = $signed(SUM_W'(clip_w));
        clip_h_s = $signed(SUM_W'(clip_h));
        x_s   = SUM_W'(x_reg);
        y_s   = SUM_W'(y_reg);
        end_x = x_s + SUM_W'(w_reg) - SUM_W'(1);
        end_y = y_s + SUM_W'(h_reg) - SUM_W'(1);
        in_clip = (x_s >= 0) && (y_s >= 0) && (x_s < clip_w_s) && (y_s < clip_h_s);
        // A run that reaches past the clip limit is cut back to end just inside it.
        len_w = (end_x >= clip_w_s) ? (clip_w_s - x_s) : SUM_W'(w_reg);
        len_h = (end_y >= clip_h_s) ? (clip_h_s - y_s) : SUM_W'(h_reg);
        w_pos = (len_w > 0);
        h_pos = (len_h > 0);

        eff_w = CNT_W'(1);
        eff_h = CNT_W'(1);
        act   = ACT_REJECT;
        case (req_reg)
            REQ_FILL:
            begin
                act = ACT_FILL;
            end
            REQ_PIXEL:
            begin
                act = ACT_DRAW;
            end
            REQ_HRUN:
            begin
                eff_w = len_w[CNT_W-1:0];
                act   = w_pos ? ACT_DRAW : ACT_EMPTY;
            end
            REQ_VRUN:
            begin
                eff_h = len_h[CNT_W-1:0];
                act   = h_pos ? ACT_DRAW : ACT_EMPTY;
            end
            REQ_RECT:
            begin
                eff_w = len_w[CNT_W-1:0];
                eff_h = len_h[CNT_W-1:0];
                act   = (w_pos && h_pos) ? ACT_DRAW : ACT_EMPTY;
            end
            REQ_READ:
            begin
                act = ACT_READ;
            end
            default:
            begin
                act = ACT_REJECT;
            end
        endcase
        if (!in_clip && (act != ACT_FILL))
        begin
            act = ACT_REJECT;
        end

        start_addr = ADDR_W'(y_reg[CNT_W-1:0]) * ADDR_W'(STORE_WIDTH)
                   + ADDR_W'(x_reg[CNT_W-1:0]);
        start_in_store = (start_addr < ADDR_W'(STORE_PIXELS));
    end

    // Address walker: rows of a rectangle, or a linear sweep of the store.
    always_comb
    begin
        addr_next = addr_reg;
        base_next = base_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (cmd.sweep_start)
        begin
            addr_next = '0;
        end
        else if (cmd.check)
        begin
            addr_next = start_addr;
            base_next = start_addr;
            col_next  = eff_w;
            row_next  = eff_h;
        end
        else if (cmd.sweep_step)
        begin
            addr_next = addr_reg + ADDR_W'(1);
        end
        else if (cmd.step)
        begin
            if (col_reg == CNT_W'(1))
            begin
                if (row_reg != CNT_W'(1))
                begin
                    base_next = base_reg + ADDR_W'(STORE_WIDTH);
                    addr_next = base_reg + ADDR_W'(STORE_WIDTH);
                    col_next  = wlen_reg;
                    row_next  = row_reg - CNT_W'(1);
                end
            end
            else
            begin
                addr_next = addr_reg + ADDR_W'(1);
                col_next  = col_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        base_reg <= base_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
        if (cmd.check)
        begin
            wlen_reg <= eff_w;
            acc_reg  <= (act != ACT_REJECT);
            hit_reg  <= (act == ACT_READ) && start_in_store;
        end
        if (cmd.sweep_start)
        begin
            zero_reg <= cmd.sweep_clear;
        end
    end

    assign addr_in_store = (addr_reg < ADDR_W'(STORE_PIXELS));
    assign ram_we        = cmd.sweep_step || (cmd.step && addr_in_store);
    assign ram_wdata     = (cmd.sweep_step && zero_reg) ? '0 : color_reg;

    ffe_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (STORE_PIXELS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg[IDX_W-1:0]),
        .wdata (ram_wdata),
        .re    (cmd.read),
        .raddr (addr_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.post)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            out_value_reg <= hit_reg ? ram_rdata : '0;
            out_acc_reg   <= acc_reg;
        end
    end

    assign rsp_valid    = out_valid_reg;
    assign read_value   = out_value_reg;
    assign was_accepted = out_acc_reg;

    assign status.act        = act;
    assign status.last_pixel = (col_reg == CNT_W'(1)) && (row_reg == CNT_W'(1));
    assign status.sweep_last = (addr_reg == ADDR_W'(STORE_PIXELS - 1));
    assign status.out_free   = !out_valid_reg || rsp_ready;

endmodule

`default_nettype wire

// File: rtl/framebuffer_fill_engine.sv
// Top level of the frame fill engine: APB register, sequencer and datapath.
// Depends on ffe_pkg, ffe_req_if, ffe_rsp_if, ffe_ctrl and ffe_datapath.
//
//   channel   direction   handshake          word
//   req       in          valid/ready        req_type, x_pos, y_pos, run_width,
//                                            run_height, pixel_color
//   rsp       out         valid/ready        read_value, was_accepted
//   apb       in          psel/penable       rotation at byte address 0
//
// One word at a time. Rejected and empty words go from the check straight to
// the result, a pixel or read touches one entry, a run or rectangle writes its
// n clipped pixels and a fill all STORE_PIXELS entries; the frame store takes
// one pixel write per cycle. After reset a clearing pass zeroes the store,
// with req.ready low. A new word is taken while a result waits on rsp; a
// finished word holds in the sequencer until the result register frees.
`default_nettype none

module framebuffer_fill_engine #(
    parameter int PANEL_WIDTH  = ffe_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = ffe_pkg::PANEL_HEIGHT_DEF,
    parameter int STORE_WIDTH  = ffe_pkg::STORE_WIDTH_DEF,
    parameter int STORE_PIXELS = ffe_pkg::STORE_PIXELS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    ffe_req_if.sink          req,
    ffe_rsp_if.source        rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import ffe_pkg::*;

    logic [1:0]  rotation_reg;
    ffe_cmd_t    cmd;
    ffe_status_t status;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ROTATION);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg <= 2'd0;
        end
        else if (cfg_write)
        begin
            rotation_reg <= pwdata[1:0];
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ROTATION: prdata = {30'd0, rotation_reg};
            default:      prdata = '0;
        endcase
    end

    ffe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ffe_datapath #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .STORE_WIDTH  (STORE_WIDTH),
        .STORE_PIXELS (STORE_PIXELS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .rotation     (rotation_reg),
        .req_type     (req.req_type),
        .x_pos        (req.x_pos),
        .y_pos        (req.y_pos),
        .run_width    (req.run_width),
        .run_height   (req.run_height),
        .pixel_color  (req.pixel_color),
        .rsp_ready    (rsp.ready),
        .rsp_valid    (rsp.valid),
        .read_value   (rsp.read_value),
        .was_accepted (rsp.was_accepted)
    );

endmodule

`default_nettype wire
